### hw/rtl/rms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_pkg: shared definitions of the running median stream block
// Widths of the item fields, the default store depth and the link type that
// carries data from one sorting cell to the next.
// ----------------------------------------------------------------------------
package rms_pkg;

	// Field widths of the input and result items.
	localparam int SAMPLE_W = 16;
	localparam int MEDIAN_W = 17;
	localparam int COUNT_W  = 7;

	// Default number of samples that the store holds.
	localparam int MAX_SAMPLES_DEF = 64;

	// What one cell hands to its right neighbor in every cycle.
	typedef struct packed {
		logic                       keep;   // this cell keeps its value on insert
		logic signed [SAMPLE_W-1:0] value;  // value held by this cell
	} cell_link_t;

endpackage

### hw/rtl/rms_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_in_if: sample channel
// Valid/ready channel that carries one sample and its end-of-stream mark.
// ----------------------------------------------------------------------------
interface rms_in_if;

	logic                                valid;
	logic                                ready;
	logic signed [rms_pkg::SAMPLE_W-1:0] sample;
	logic                                last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);

endinterface

### hw/rtl/rms_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_out_if: result channel
// Valid/ready channel that carries the running median and its status bits.
// ----------------------------------------------------------------------------
interface rms_out_if;

	logic                                valid;
	logic                                ready;
	logic signed [rms_pkg::MEDIAN_W-1:0] median_twice;
	logic        [rms_pkg::COUNT_W-1:0]  count;
	logic                                overflow;
	logic                                final_res;

	modport source (
		output valid, output median_twice, output count, output overflow,
		output final_res, input ready
	);
	modport sink (
		input valid, input median_twice, input count, input overflow,
		input final_res, output ready
	);

endinterface

### hw/rtl/running_median_stream.sv
// Path: the row of compare-and-shift cells inserts an accepted sample; the
// middle entries are then read into the result register once it is free.
// Throughput: one item per cycle while results.ready stays high.
// Reset: arst_n clears the held count and the handshake state at once; the
// cell contents are not reset and are only read below the held count.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_median_stream: running median of a sample stream
// Keeps the samples of the current stream sorted in a row of cells and
// returns twice the median after each item. A last-marked item empties the
// store after its result.
// ----------------------------------------------------------------------------
module running_median_stream #(
	parameter int MAX_SAMPLES = rms_pkg::MAX_SAMPLES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rms_in_if.sink    samples,
	rms_out_if.source results
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

	// Store fill state.
	logic [CNT_W-1:0] held_count_q;
	logic [CNT_W-1:0] count_next;
	logic             full;
	logic             accept;
	logic             ins_en;

	// Insert stage and result register.
	logic                                pend_q;
	logic [CNT_W-1:0]                    count_s1;
	logic                                overflow_s1;
	logic                                last_s1;
	logic                                load;
	logic                                res_valid_q;
	logic signed [rms_pkg::MEDIAN_W-1:0] median_q;
	logic [rms_pkg::COUNT_W-1:0]         count_q;
	logic                                overflow_q;
	logic                                final_q;
	logic [CNT_W-1:0]                    res_count_q;

	// Cell row.
	rms_pkg::cell_link_t                 head;
	rms_pkg::cell_link_t                 links [MAX_SAMPLES];
	logic signed [rms_pkg::SAMPLE_W-1:0] vals  [MAX_SAMPLES];
	logic signed [rms_pkg::MEDIAN_W-1:0] median_twice;

	// Handshake: a new item enters while the insert stage is free or drains.
	assign load          = pend_q && (!res_valid_q || results.ready);
	assign samples.ready = !pend_q || load;
	assign accept        = samples.valid && samples.ready;

	// A full store drops the sample.
	assign full       = (held_count_q == CNT_W'(MAX_SAMPLES));
	assign ins_en     = accept && !full;
	assign count_next = full ? held_count_q : held_count_q + CNT_W'(1);

	// The first cell takes the sample whenever it does not keep its value.
	assign head.keep  = 1'b1;
	assign head.value = '0;

	for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
		rms_pkg::cell_link_t prev_link;

		if (g == 0) begin : g_first
			assign prev_link = head;
		end else begin : g_rest
			assign prev_link = links[g-1];
		end

		rms_cell #(
			.INDEX (g),
			.CNT_W (CNT_W)
		) u_cell (
			.clk    (clk),
			.ins_en (ins_en),
			.sample (samples.sample),
			.count  (held_count_q),
			.prev   (prev_link),
			.nxt    (links[g])
		);

		assign vals[g] = links[g].value;
	end

	rms_median #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.CNT_W       (CNT_W)
	) u_median (
		.vals         (vals),
		.count        (count_s1),
		.median_twice (median_twice)
	);

	// Held count; a last-marked item empties the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= '0;
		end else if (accept) begin
			held_count_q <= samples.last ? '0 : count_next;
		end
	end

	// Insert stage occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (accept) begin
			pend_q <= 1'b1;
		end else if (load) begin
			pend_q <= 1'b0;
		end
	end

	// Status of the item in the insert stage.
	always_ff @(posedge clk) begin
		if (accept) begin
			count_s1    <= count_next;
			overflow_s1 <= full;
			last_s1     <= samples.last;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			median_q    <= median_twice;
			count_q     <= rms_pkg::COUNT_W'(count_s1);
			res_count_q <= count_s1;
			overflow_q  <= overflow_s1;
			final_q     <= last_s1;
		end
	end

	assign results.valid        = res_valid_q;
	assign results.median_twice = median_q;
	assign results.count        = count_q;
	assign results.overflow     = overflow_q;
	assign results.final_res    = final_q;

`ifndef SYNTHESIS
	// The store never holds more than its depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= CNT_W'(MAX_SAMPLES))
		else $error("held count above store depth");

	// A dropped sample is only reported with a full store.
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && overflow_q |-> res_count_q == CNT_W'(MAX_SAMPLES))
		else $error("overflow reported with room left");

	// A last-marked item empties the store.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && samples.last |=> held_count_q == '0)
		else $error("store not emptied after last item");

	// An item in the insert stage is not lost while the result register waits.
	a_pend_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q && !load |=> pend_q)
		else $error("pending item lost");

	// Every result reports at least one held sample.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_count_q != '0)
		else $error("result with empty store");
`endif

endmodule

### hw/rtl/rms_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_cell: one compare-and-shift cell of the sorted store
// Holds one store entry. On an insert it keeps its value, takes the new
// sample, or takes the value of its left neighbor.
// ----------------------------------------------------------------------------
module rms_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 7
) (
	input  logic                                clk,
	input  logic                                ins_en,
	input  logic signed [rms_pkg::SAMPLE_W-1:0] sample,
	input  logic        [CNT_W-1:0]             count,
	input  rms_pkg::cell_link_t                 prev,
	output rms_pkg::cell_link_t                 nxt
);

	logic signed [rms_pkg::SAMPLE_W-1:0] value_q;
	logic                                keep;

	// An occupied entry not above the sample stays where it is, so equal
	// samples end up after the ones already held.
	assign keep = (CNT_W'(INDEX) < count) && (value_q <= sample);

	assign nxt.keep  = keep;
	assign nxt.value = value_q;

	// Keep, take the sample at the insert point, or shift right by one.
	always_ff @(posedge clk) begin
		if (ins_en && !keep) begin
			if (prev.keep) begin
				value_q <= sample;
			end else begin
				value_q <= prev.value;
			end
		end
	end

endmodule

### hw/rtl/rms_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_median: middle-entry selection
// Picks the one or two middle entries of the sorted row and adds them, which
// gives twice the median.
// ----------------------------------------------------------------------------
module rms_median #(
	parameter int MAX_SAMPLES = rms_pkg::MAX_SAMPLES_DEF,
	parameter int CNT_W       = 7
) (
	input  logic signed [rms_pkg::SAMPLE_W-1:0] vals [MAX_SAMPLES],
	input  logic        [CNT_W-1:0]             count,
	output logic signed [rms_pkg::MEDIAN_W-1:0] median_twice
);

	logic [CNT_W-1:0]             hi_idx;
	logic [CNT_W-1:0]             lo_idx;
	logic [rms_pkg::SAMPLE_W-1:0] hi_val;
	logic [rms_pkg::SAMPLE_W-1:0] lo_val;

	// With an odd count both picks are the middle entry.
	assign hi_idx = count >> 1;
	assign lo_idx = count[0] ? hi_idx : hi_idx - CNT_W'(1);

	// One-hot AND-OR selection across the row of cells.
	always_comb begin
		hi_val = '0;
		lo_val = '0;
		for (int i = 0; i < MAX_SAMPLES; i++) begin
			hi_val = hi_val | (vals[i] & {rms_pkg::SAMPLE_W{CNT_W'(i) == hi_idx}});
			lo_val = lo_val | (vals[i] & {rms_pkg::SAMPLE_W{CNT_W'(i) == lo_idx}});
		end
	end

	// Sign-extended sum of the two middle entries.
	assign median_twice = $signed({hi_val[rms_pkg::SAMPLE_W-1], hi_val})
		+ $signed({lo_val[rms_pkg::SAMPLE_W-1], lo_val});

endmodule
